FILE: rtl/core/nsc_pkg.sv
// Shared types, character constants and helper functions of the NMEA sentence checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nsc_pkg;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;   // '$'
   localparam logic [7:0] CH_STAR    = 8'h2A;   // '*'
   localparam logic [7:0] CH_N       = 8'h4E;   // 'N', second header letter of GNGGA
   localparam logic [7:0] CH_ZERO    = 8'h30;   // '0'
   localparam logic [7:0] CH_UPPER_A = 8'h41;   // 'A'

   localparam logic [3:0] MIN_LENGTH = 4'd8;    // characters from '$' on
   localparam logic [1:0] TAIL_LEN   = 2'd2;    // checksum digits after '*'
   localparam logic [1:0] TAIL_SAT   = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ST_NO_DOLLAR   = 3'd0,
      ST_BAD_FRAME   = 3'd1,
      ST_MISMATCH    = 3'd2,
      ST_VALID_OTHER = 3'd3,
      ST_VALID_GGA   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] computed_sum;
   } rsp_type;

   // Summary of one finished line, handed from the front to the back.
   typedef struct packed {
      logic       have_start;
      logic [7:0] xor_sum;
      logic       long_enough;
      logic       star_seen;
      logic [1:0] tail_count;
      logic [7:0] tail_high;
      logic [7:0] tail_low;
      logic       header_match;
   } line_sum_type;

   // Expected header letter at position pos after '$' (GPGGA).
   function automatic logic [7:0] hdr_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd1:    ch = 8'h47;   // 'G'
         4'd2:    ch = 8'h50;   // 'P'
         4'd3:    ch = 8'h47;   // 'G'
         4'd4:    ch = 8'h47;   // 'G'
         4'd5:    ch = 8'h41;   // 'A'
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Uppercase hexadecimal character of one nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'b0000, nib};
      end else begin
         ch = CH_UPPER_A + {4'b0000, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nsc_front.sv
// Front of the NMEA sentence checker: takes characters, tracks framing and the running XOR.
// Depends on nsc_pkg; pushes one line summary per line end into nsc_queue.
`default_nettype none

module nsc_front
   import nsc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   input  wire logic         queue_full,
   output logic              push_valid,
   output line_sum_type      push_data
);

   logic       have_start_ff,   have_start_in;
   logic [7:0] xor_accum_ff,    xor_accum_in;
   logic [3:0] length_count_ff, length_count_in;
   logic       star_seen_ff,    star_seen_in;
   logic [1:0] tail_count_ff,   tail_count_in;
   logic [7:0] tail_high_ff,    tail_high_in;
   logic [7:0] tail_low_ff,     tail_low_in;
   logic       header_match_ff, header_match_in;
   logic       accept;
   logic [7:0] ch;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && req_data.line_end;
   assign ch         = req_data.char_in;

   // Fold one character into the line state.
   always_comb begin
      have_start_in   = have_start_ff;
      xor_accum_in    = xor_accum_ff;
      length_count_in = length_count_ff;
      star_seen_in    = star_seen_ff;
      tail_count_in   = tail_count_ff;
      tail_high_in    = tail_high_ff;
      tail_low_in     = tail_low_ff;
      header_match_in = header_match_ff;
      if (ch == CH_DOLLAR) begin
         have_start_in   = 1'b1;
         xor_accum_in    = 8'h00;
         length_count_in = 4'd1;
         star_seen_in    = 1'b0;
         tail_count_in   = 2'd0;
         tail_high_in    = 8'h00;
         tail_low_in     = 8'h00;
         header_match_in = 1'b1;
      end else if (have_start_ff) begin
         if (length_count_ff < MIN_LENGTH) begin
            length_count_in = length_count_ff + 4'd1;
         end
         if (length_count_ff >= 4'd1 && length_count_ff <= 4'd5) begin
            if (!(ch == hdr_char(length_count_ff) ||
                  (length_count_ff == 4'd2 && ch == CH_N))) begin
               header_match_in = 1'b0;
            end
         end
         if (!star_seen_ff) begin
            if (ch == CH_STAR) begin
               star_seen_in = 1'b1;
            end else begin
               xor_accum_in = xor_accum_ff ^ ch;
            end
         end else begin
            if (tail_count_ff == 2'd0) begin
               tail_high_in = ch;
            end else if (tail_count_ff == 2'd1) begin
               tail_low_in = ch;
            end
            if (tail_count_ff < TAIL_SAT) begin
               tail_count_in = tail_count_ff + 2'd1;
            end
         end
      end
   end

   always_comb begin
      push_data.have_start   = have_start_in;
      push_data.xor_sum      = xor_accum_in;
      push_data.long_enough  = (length_count_in >= MIN_LENGTH);
      push_data.star_seen    = star_seen_in;
      push_data.tail_count   = tail_count_in;
      push_data.tail_high    = tail_high_in;
      push_data.tail_low     = tail_low_in;
      push_data.header_match = header_match_in;
   end

   // Clear at reset and after every line end; otherwise advance on accept.
   always_ff @(posedge clock) begin
      if (reset || push_valid) begin
         have_start_ff   <= 1'b0;
         xor_accum_ff    <= 8'h00;
         length_count_ff <= 4'd0;
         star_seen_ff    <= 1'b0;
         tail_count_ff   <= 2'd0;
         tail_high_ff    <= 8'h00;
         tail_low_ff     <= 8'h00;
         header_match_ff <= 1'b0;
      end else if (accept) begin
         have_start_ff   <= have_start_in;
         xor_accum_ff    <= xor_accum_in;
         length_count_ff <= length_count_in;
         star_seen_ff    <= star_seen_in;
         tail_count_ff   <= tail_count_in;
         tail_high_ff    <= tail_high_in;
         tail_low_ff     <= tail_low_in;
         header_match_ff <= header_match_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/nsc_queue.sv
// Short queue of line summaries between front and back of the NMEA sentence checker.
// Depends on nsc_pkg for the summary type.
`default_nettype none

module nsc_queue
   import nsc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire line_sum_type  push_data,
   output logic               queue_full,
   input  wire logic          pop,
   output logic               q_valid,
   output line_sum_type       q_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   line_sum_type    slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push;
   logic            do_pop;

   assign queue_full = (count_ff == FullCnt);
   assign q_valid    = (count_ff != '0);
   assign q_data     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/nsc_back.sv
// Back of the NMEA sentence checker: judges one line summary and holds the result word.
// Depends on nsc_pkg; pops summaries from nsc_queue.
`default_nettype none

module nsc_back
   import nsc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire line_sum_type  q_data,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    verdict;
   status_type status;

   always_comb begin
      verdict.computed_sum = q_data.xor_sum;
      if (!q_data.have_start) begin
         status               = ST_NO_DOLLAR;
         verdict.computed_sum = 8'h00;
      end else if (!q_data.star_seen || q_data.tail_count != TAIL_LEN ||
                   !q_data.long_enough) begin
         status = ST_BAD_FRAME;
      end else if (q_data.tail_high != hex_digit(q_data.xor_sum[7:4]) ||
                   q_data.tail_low  != hex_digit(q_data.xor_sum[3:0])) begin
         status = ST_MISMATCH;
      end else if (q_data.header_match) begin
         status = ST_VALID_GGA;
      end else begin
         status = ST_VALID_OTHER;
      end
      verdict.status = status;
   end

   // Load a new word whenever the output register is empty or being taken.
   assign pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/nmea_sentence_checker.sv
// NMEA 0183 sentence checker (top level).
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
//
// Usage:
//   req channel: one raw character per word (req_data.char_in) with
//   req_data.line_end set on the last character of a line. The last '$' of a
//   line starts the sentence; the characters up to the first '*' are XORed.
//   rsp channel: one word per line, sent after the line-end character:
//   status (no '$', bad framing, checksum mismatch, valid other, valid GGA)
//   and the computed checksum. Characters that are not line ends give no word.
// Timing:
//   one character per cycle while the queue is not full; each character
//   updates the front state registers. A line-end character accepted at an
//   edge is written into the queue at that same edge; its summary is judged
//   from the queue and loaded into rsp_data once the output register is free.
// Stalls:
//   the front keeps taking characters while a result waits in the output
//   register; a queue of QueueDepth line summaries absorbs the back pressure,
//   and req_ready drops only when that queue is full.
// Reset:
//   synchronous, active high; clears line state, queue and output valid.
`default_nettype none

module nmea_sentence_checker
   import nsc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic         queue_full;
   logic         push_valid;
   line_sum_type push_data;
   logic         pop;
   logic         q_valid;
   line_sum_type q_data;

   // Front: accept characters, classify, and summarize each line.
   nsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Hold finished line summaries until the back is free.
   nsc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_data     (q_data)
   );

   // Back: judge checksum and framing, drive the result word.
   nsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Never push a line summary into a full queue.
   assert property (@(posedge clock) disable iff (reset) push_valid |-> !queue_full)
      else $error("line summary pushed into full queue");

   // A pushed summary is waiting in the queue at the next edge.
   assert property (@(posedge clock) disable iff (reset) push_valid |=> q_valid)
      else $error("pushed line summary missing from queue");

   // A line without '$' always reports a zero checksum.
   assert property (@(posedge clock) disable iff (reset)
         (rsp_valid && rsp_data.status == ST_NO_DOLLAR) |-> rsp_data.computed_sum == 8'h00)
      else $error("nonzero checksum reported for line without start");
`endif

endmodule

`default_nettype wire
